>>> rtl/core/lfsc_pkg.sv
// Shared types and constants for the line follower steering control core.
// Holds the request and result payload structs, register indexes and pattern codes.
// No dependencies.
package lfsc_pkg;

  typedef struct packed {
    logic [3:0] sensor_bits;
    logic [3:0] switch_bits;
  } sample_t;

  typedef struct packed {
    logic [9:0]  servo_duty;
    logic [11:0] traction_duty;
    logic [3:0]  line_pattern;
    logic [3:0]  trim_count;
  } result_t;

  localparam int AddrWidth = 4;

  localparam logic [1:0] RegBaseSpeed      = 2'd0;
  localparam logic [1:0] RegSensorGain     = 2'd1;
  localparam logic [1:0] RegServoGain      = 2'd2;
  localparam logic [1:0] RegSensorThresh   = 2'd3;

  localparam logic [11:0] BaseSpeedReset   = 12'd707;
  localparam logic [16:0] GainReset        = 17'd52429;
  localparam logic [16:0] ThreshReset      = 17'd13107;
  localparam logic [16:0] OneQ16           = 17'h10000;
  localparam logic [12:0] TractionMax      = 13'd2500;
  localparam logic [9:0]  ServoMax         = 10'd1000;
  localparam logic [9:0]  ServoReset       = 10'd750;
  localparam logic [11:0] TractionReset    = 12'd750;

  localparam logic [3:0] Pat1110 = 4'b1110;
  localparam logic [3:0] Pat1000 = 4'b1000;
  localparam logic [3:0] Pat1100 = 4'b1100;
  localparam logic [3:0] Pat1101 = 4'b1101;
  localparam logic [3:0] Pat1001 = 4'b1001;
  localparam logic [3:0] Pat1011 = 4'b1011;
  localparam logic [3:0] Pat0011 = 4'b0011;
  localparam logic [3:0] Pat0001 = 4'b0001;
  localparam logic [3:0] Pat0111 = 4'b0111;
  localparam logic [3:0] Pat1111 = 4'b1111;

endpackage

>>> rtl/core/line_follower_steering_control_core.sv
// Line follower steering control core: sensor filters, pattern decode, speed trim,
// traction and servo duty. Depends on lfsc_pkg.
//
// Usage:
//   sample channel (sample_valid / sample_stall / sample) carries one control tick:
//   four raw reflectance bits and four switch levels. A request is taken at a rising
//   edge with sample_valid high and sample_stall low.
//   result channel (result_valid / result_stall / result) returns one result per
//   request: servo duty, traction duty, thresholded line pattern and trim count.
//   The APB port sets base speed, sensor gain, servo gain and sensor threshold at
//   byte addresses 0, 4, 8 and 12; write only while no request is in flight.
// Timing:
//   Filters, pattern, trim and traction update in the cycle a request is taken;
//   the servo blend multiply sits in a second stage. A result passes from the first
//   stage registers into the result register.
//   One request per cycle is sustained while result_stall stays low, set by the
//   combinational filter multiply loop through the filtered levels.
// Reset:
//   rst (synchronous) restores register defaults, clears filters and trim count,
//   sets servo target and traction duty to 750, and empties both stages.
// Stall:
//   While result_stall is high the result holds; one more request is still taken
//   into the first stage, after which sample_stall rises.
module line_follower_steering_control_core
  import lfsc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 sample_valid,
  output logic                 sample_stall,
  input  sample_t              sample,
  output logic                 result_valid,
  input  logic                 result_stall,
  output result_t              result,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  logic [11:0] base_speed;
  logic [16:0] sensor_gain;
  logic [16:0] servo_gain;
  logic [16:0] sensor_threshold;

  logic [3:0]  prev_switches;
  logic [3:0]  trim_counter;
  logic [16:0] filtered_level [4];
  logic [9:0]  servo_target;
  logic [11:0] traction_hold;

  logic        s1_valid;
  logic [9:0]  s1_ref;
  logic [9:0]  s1_target;
  logic [11:0] s1_traction;
  logic [3:0]  s1_pattern;
  logic [3:0]  s1_trim;

  logic        accept;
  logic        s1_move;
  logic        cfg_write;
  logic [1:0]  cfg_index;

  logic [16:0] sensor_g;
  logic [16:0] servo_s;
  logic [3:0]  rise;
  logic [3:0]  trim_counter_next;
  logic [33:0] filt_acc [4];
  logic [16:0] filtered_level_next [4];
  logic [3:0]  pattern;
  logic [9:0]  servo_target_next;
  logic [9:0]  ref_value;
  logic [4:0]  offset;
  logic        hit;
  logic [12:0] speed;
  logic [11:0] traction_hold_next;
  logic [27:0] servo_acc;

  // configuration port
  assign pready    = 1'b1;
  assign cfg_index = paddr[3:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_speed       <= BaseSpeedReset;
      sensor_gain      <= GainReset;
      servo_gain       <= GainReset;
      sensor_threshold <= ThreshReset;
    end else if (cfg_write) begin
      case (cfg_index)
        RegBaseSpeed:    base_speed       <= pwdata[11:0];
        RegSensorGain:   sensor_gain      <= pwdata[16:0];
        RegServoGain:    servo_gain       <= pwdata[16:0];
        RegSensorThresh: sensor_threshold <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_index)
      RegBaseSpeed:    prdata = {20'd0, base_speed};
      RegSensorGain:   prdata = {15'd0, sensor_gain};
      RegServoGain:    prdata = {15'd0, servo_gain};
      RegSensorThresh: prdata = {15'd0, sensor_threshold};
      default:         prdata = 32'd0;
    endcase
  end

  // handshake
  assign s1_move      = s1_valid && (!result_valid || !result_stall);
  assign sample_stall = s1_valid && !s1_move;
  assign accept       = sample_valid && !sample_stall;

  // stage 1: trim, filters, pattern, traction
  assign sensor_g = (sensor_gain > OneQ16) ? OneQ16 : sensor_gain;
  assign servo_s  = (servo_gain > OneQ16) ? OneQ16 : servo_gain;

  assign rise              = sample.switch_bits & ~prev_switches;
  assign trim_counter_next = trim_counter + rise;

  always_comb begin
    for (int b = 0; b < 4; b++) begin
      filt_acc[b] = sensor_g * filtered_level[b];
      if (sample.sensor_bits[b]) begin
        filt_acc[b] = filt_acc[b] + {1'b0, 17'(OneQ16 - sensor_g), 16'd0};
      end
      filtered_level_next[b] = filt_acc[b][32:16];
      pattern[b]             = filtered_level_next[b] > sensor_threshold;
    end
  end

  always_comb begin
    hit               = 1'b1;
    servo_target_next = servo_target;
    ref_value         = servo_target;
    offset            = 5'd0;
    case (pattern)
      Pat1110: begin
        servo_target_next = 10'd500;  ref_value = 10'd500;  offset = 5'd12;
      end
      Pat1000: begin
        servo_target_next = 10'd600;  ref_value = 10'd600;  offset = 5'd10;
      end
      Pat1100: begin
        servo_target_next = 10'd650;  offset = 5'd5;
      end
      Pat1101: begin
        servo_target_next = 10'd700;  offset = 5'd2;
      end
      Pat1001: begin
        servo_target_next = 10'd750;  ref_value = 10'd750;  offset = 5'd0;
      end
      Pat1011: begin
        servo_target_next = 10'd800;  offset = 5'd2;
      end
      Pat0011: begin
        servo_target_next = 10'd850;  offset = 5'd5;
      end
      Pat0001: begin
        servo_target_next = 10'd900;  ref_value = 10'd900;  offset = 5'd10;
      end
      Pat0111: begin
        servo_target_next = 10'd1000; ref_value = 10'd1000; offset = 5'd12;
      end
      Pat1111: begin
        offset = 5'd20;
      end
      default: begin
        hit = 1'b0;
      end
    endcase
  end

  assign speed = {1'b0, base_speed} + 13'(trim_counter_next) + 13'(offset);

  always_comb begin
    if (!hit) begin
      traction_hold_next = traction_hold;
    end else if (speed > TractionMax) begin
      traction_hold_next = TractionMax[11:0];
    end else begin
      traction_hold_next = speed[11:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_switches <= 4'hF;
      trim_counter  <= 4'd0;
      servo_target  <= ServoReset;
      traction_hold <= TractionReset;
      for (int b = 0; b < 4; b++) begin
        filtered_level[b] <= 17'd0;
      end
    end else if (accept) begin
      prev_switches <= sample.switch_bits;
      trim_counter  <= trim_counter_next;
      servo_target  <= servo_target_next;
      traction_hold <= traction_hold_next;
      for (int b = 0; b < 4; b++) begin
        filtered_level[b] <= filtered_level_next[b];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ref      <= ref_value;
      s1_target   <= servo_target_next;
      s1_traction <= traction_hold_next;
      s1_pattern  <= pattern;
      s1_trim     <= trim_counter_next;
    end
  end

  // stage 2: servo blend
  assign servo_acc = 28'(servo_s * s1_ref) + 28'(17'(OneQ16 - servo_s) * s1_target);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_move) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      result.servo_duty    <= servo_acc[25:16];
      result.traction_duty <= s1_traction;
      result.line_pattern  <= s1_pattern;
      result.trim_count    <= s1_trim;
    end
  end

  a_traction_cap: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ({1'b0, result.traction_duty} <= TractionMax))
    else $error("traction duty above saturation limit");

  a_servo_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.servo_duty <= ServoMax))
    else $error("servo duty out of range");

  a_stage_filled: assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_valid)
    else $error("accepted request missing from first stage");

  a_filter_bound: assert property (@(posedge clk) disable iff (rst)
    (filtered_level[0] <= OneQ16) && (filtered_level[1] <= OneQ16) &&
    (filtered_level[2] <= OneQ16) && (filtered_level[3] <= OneQ16))
    else $error("filtered level above one");

endmodule
